// ----- rtl/core/ple_pkg.sv -----
// Shared definitions for the positional list engine: field widths, operation
// and status codes, and the command/status structs between controller and datapath.
// No dependencies.
package ple_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 8;
	localparam int LEN_W  = 9;

	localparam int DEF_DEPTH = 256;
	localparam int DEF_WIDTH = 32;

	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
	localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
	localparam logic [OP_W-1:0] OP_READ    = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic              load;
		logic              shift_up;
		logic              shift_dn;
		logic              scan;
		logic              put_val;
		logic              dec_cnt;
		logic              clr_cnt;
		logic              take_rd;
		logic              rev_wa;
		logic              rev_wb;
		logic              set_st;
		logic [STAT_W-1:0] st;
		logic              publish;
	} ple_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ins_bad;
		logic            full;
		logic            pos_oob;
		logic            ins_done;
		logic            rem_done;
		logic            scan_done;
		logic            rev_done;
		logic            out_free;
	} ple_sts_t;

endpackage

// ----- rtl/core/ple_if.sv -----
// Valid/ready channel interfaces for requests and results of the list engine.
// Depends on ple_pkg.
interface ple_req_if import ple_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] item_value;

	modport source(output valid, output operation, output position, output item_value,
		input ready);
	modport sink(input valid, input operation, input position, input item_value,
		output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0]  read_value;
	logic [IDX_W-1:0]  found_index;
	logic [LEN_W-1:0]  list_length;

	modport source(output valid, output status, output read_value, output found_index,
		output list_length, input ready);
	modport sink(input valid, input status, input read_value, input found_index,
		input list_length, output ready);
endinterface

// ----- rtl/core/ple_ctrl.sv -----
// Controller of the list engine: sequences each request through the datapath.
// Depends on ple_pkg.
module ple_ctrl import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ple_sts_t sts,
	output ple_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_INS    = 4'd2;
	localparam logic [3:0] S_REM    = 4'd3;
	localparam logic [3:0] S_SRCH   = 4'd4;
	localparam logic [3:0] S_READ   = 4'd5;
	localparam logic [3:0] S_REV_RD = 4'd6;
	localparam logic [3:0] S_REV_WA = 4'd7;
	localparam logic [3:0] S_REV_WB = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_INSERT: begin
						if (sts.ins_bad) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_BAD_POS;
							state_d    = S_FIN;
						end else if (sts.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_FULL;
							state_d    = S_FIN;
						end else begin
							state_d = S_INS;
						end
					end
					OP_REMOVE: begin
						if (sts.pos_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_BAD_POS;
							state_d    = S_FIN;
						end else begin
							state_d = S_REM;
						end
					end
					OP_SEARCH: begin
						// Assume a miss; a match in the scan overrides it.
						cmd.set_st = 1'b1;
						cmd.st     = ST_NOT_FOUND;
						state_d    = S_SRCH;
					end
					OP_READ: begin
						if (sts.pos_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_BAD_POS;
							state_d    = S_FIN;
						end else begin
							state_d = S_READ;
						end
					end
					OP_CLEAR: begin
						cmd.clr_cnt = 1'b1;
						state_d     = S_FIN;
					end
					OP_REVERSE: begin
						state_d = S_REV_RD;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_INS: begin
				if (sts.ins_done) begin
					cmd.put_val = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.shift_up = 1'b1;
				end
			end
			S_REM: begin
				if (sts.rem_done) begin
					cmd.dec_cnt = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.shift_dn = 1'b1;
				end
			end
			S_SRCH: begin
				if (sts.scan_done) begin
					state_d = S_FIN;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_READ: begin
				cmd.take_rd = 1'b1;
				state_d     = S_FIN;
			end
			S_REV_RD: begin
				state_d = sts.rev_done ? S_FIN : S_REV_WA;
			end
			S_REV_WA: begin
				cmd.rev_wa = 1'b1;
				state_d    = S_REV_WB;
			end
			S_REV_WB: begin
				cmd.rev_wb = 1'b1;
				state_d    = S_REV_RD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/ple_dpath.sv -----
// Datapath of the list engine: entry memory, length count, walk pointers,
// working result and the output register. Depends on ple_pkg.
module ple_dpath import ple_pkg::*; #(
	parameter int DEPTH = DEF_DEPTH,
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [OP_W-1:0]   in_operation,
	input  logic [POS_W-1:0]  in_position,
	input  logic [VAL_W-1:0]  in_item_value,
	input  ple_cmd_t          cmd,
	output ple_sts_t          sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] out_status,
	output logic [VAL_W-1:0]  out_read_value,
	output logic [IDX_W-1:0]  out_found_index,
	output logic [LEN_W-1:0]  out_list_length
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// Pointers must also hold a request position plus one.
	localparam int PW = (CW > POS_W + 1) ? CW : POS_W + 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	logic [CW-1:0]     cnt_q;
	logic              pend_q;
	logic              found_q;
	logic              out_valid_q;
	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [WIDTH-1:0]  val_q;
	logic [PW-1:0]     ptr_q;
	logic [PW-1:0]     hi_q;
	logic [IW-1:0]     paddr_q;
	logic [STAT_W-1:0] res_st_q;
	logic [VAL_W-1:0]  res_rd_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [STAT_W-1:0] out_st_q;
	logic [VAL_W-1:0]  out_rd_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [LEN_W-1:0]  out_len_q;

	logic [PW-1:0]    pos_ext;
	logic [PW-1:0]    cnt_ext;
	logic [PW-1:0]    ptr_dec;
	logic [PW-1:0]    ptr_inc;
	logic [PW-1:0]    ptr_init;
	logic [IW-1:0]    raddr_a;
	logic             issue;
	logic             match;
	logic             we;
	logic [IW-1:0]    waddr;
	logic [WIDTH-1:0] wdata;

	assign pos_ext = PW'(pos_q);
	assign cnt_ext = PW'(cnt_q);
	assign ptr_dec = ptr_q - PW'(1);
	assign ptr_inc = ptr_q + PW'(1);
	// An insert walks down from the top and reads the entry below the pointer.
	assign raddr_a = cmd.shift_up ? ptr_dec[IW-1:0] : ptr_q[IW-1:0];

	assign issue = (cmd.shift_up && (ptr_q > pos_ext)) ||
		(cmd.shift_dn && (ptr_q < cnt_ext)) ||
		(cmd.scan && (ptr_q < cnt_ext) && !found_q);
	assign match = cmd.scan && pend_q && !found_q && (rdata_a_q == val_q);

	always_comb begin
		case (in_operation)
			OP_INSERT: ptr_init = cnt_ext;
			OP_REMOVE: ptr_init = PW'(in_position) + PW'(1);
			OP_READ:   ptr_init = PW'(in_position);
			default:   ptr_init = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q[IW-1:0];
		wdata = rdata_a_q;
		if (cmd.shift_up && pend_q) begin
			we    = 1'b1;
			waddr = paddr_q + IW'(1);
		end else if (cmd.shift_dn && pend_q) begin
			we    = 1'b1;
			waddr = paddr_q - IW'(1);
		end else if (cmd.put_val) begin
			we    = 1'b1;
			waddr = IW'(pos_q);
			wdata = val_q;
		end else if (cmd.rev_wa) begin
			we    = 1'b1;
			wdata = rdata_b_q;
		end else if (cmd.rev_wb) begin
			we    = 1'b1;
			waddr = hi_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[hi_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.shift_up || cmd.shift_dn || cmd.scan) begin
				pend_q <= issue;
			end
			if (match) begin
				found_q <= 1'b1;
			end
			if (cmd.put_val) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec_cnt) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_operation;
			pos_q     <= in_position;
			val_q     <= WIDTH'(in_item_value);
			ptr_q     <= ptr_init;
			hi_q      <= (cnt_q == '0) ? '0 : cnt_ext - PW'(1);
			res_st_q  <= ST_OK;
			res_rd_q  <= '0;
			res_idx_q <= '0;
		end else begin
			if (issue) begin
				ptr_q   <= cmd.shift_up ? ptr_dec : ptr_inc;
				paddr_q <= raddr_a;
			end else if (cmd.rev_wb) begin
				ptr_q <= ptr_inc;
				hi_q  <= hi_q - PW'(1);
			end
			if (cmd.set_st) begin
				res_st_q <= cmd.st;
			end
			if (match) begin
				res_st_q  <= ST_OK;
				res_idx_q <= IDX_W'(paddr_q);
			end
			if (cmd.take_rd) begin
				res_rd_q <= VAL_W'(rdata_a_q);
			end
		end
		if (cmd.publish) begin
			out_st_q  <= res_st_q;
			out_rd_q  <= res_rd_q;
			out_idx_q <= res_idx_q;
			out_len_q <= LEN_W'(cnt_q);
		end
	end

	assign sts.op        = op_q;
	assign sts.ins_bad   = pos_ext > cnt_ext;
	assign sts.full      = (cnt_q == CW'(DEPTH));
	assign sts.pos_oob   = pos_ext >= cnt_ext;
	assign sts.ins_done  = (ptr_q == pos_ext) && !pend_q;
	assign sts.rem_done  = (ptr_q >= cnt_ext) && !pend_q;
	assign sts.scan_done = found_q || ((ptr_q >= cnt_ext) && !pend_q);
	assign sts.rev_done  = ptr_q >= hi_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_status      = out_st_q;
	assign out_read_value  = out_rd_q;
	assign out_found_index = out_idx_q;
	assign out_list_length = out_len_q;

endmodule

// ----- rtl/core/positional_list_engine.sv -----
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_if, ple_ctrl and ple_dpath.
//
// An ordered list of up to DEPTH values of WIDTH bits kept in one memory
// with a length count. One request is worked on at a time; each returns
// exactly one result. The walks move one entry per cycle through the
// memory's single write port, and reverse spends one two-port read and two
// writes on each swapped pair. A finished request holds in its final state
// until the output register is free. A new request is taken while the
// previous result still waits in the output register.
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH = DEF_DEPTH,
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic   clk,
	input  logic   arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	ple_cmd_t cmd;
	ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ple_dpath #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_operation    (req.operation),
		.in_position     (req.position),
		.in_item_value   (req.item_value),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_read_value  (rsp.read_value),
		.out_found_index (rsp.found_index),
		.out_list_length (rsp.list_length)
	);

endmodule

// ----- rtl/core/ple_checker.sv -----
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_port_checks import ple_pkg::*; #(
	parameter int DEPTH = DEF_DEPTH
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] status,
	input logic [VAL_W-1:0]  read_value,
	input logic [IDX_W-1:0]  found_index,
	input logic [LEN_W-1:0]  list_length
);

	logic             has_prev_q;
	logic [LEN_W-1:0] prev_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_prev_q <= 1'b0;
			prev_len_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			has_prev_q <= 1'b1;
			prev_len_q <= list_length;
		end
	end

	// A held result keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(read_value) && $stable(found_index) && $stable(list_length))
		else $error("result changed while stalled");

	// One request in flight: the engine is busy right after taking an item.
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

	// Each result changes the length by at most one, or clears it.
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && has_prev_q |->
		(list_length == '0) || (list_length == prev_len_q) ||
		(list_length == prev_len_q + LEN_W'(1)) ||
		(list_length + LEN_W'(1) == prev_len_q))
		else $error("length jumped between results");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> (list_length == LEN_W'(DEPTH)))
		else $error("full status with list not full");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((found_index != '0) || (read_value != '0)) |-> (status == ST_OK))
		else $error("value or index returned with failing status");

endmodule

bind positional_list_engine ple_port_checks #(.DEPTH(DEPTH)) u_ple_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.read_value  (rsp.read_value),
	.found_index (rsp.found_index),
	.list_length (rsp.list_length)
);

// ----- test/ple_checker.sv -----
// Result checker for the positional list engine: watches the request and result
// channels, predicts each result from its own copy of the list, and compares.
// Depends on ple_pkg and ple_if.
module ple_checker import ple_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ple_req_if               req,
	ple_rsp_if               rsp,
	output int               fail_count,
	output int               pending_count,
	output logic [LEN_W-1:0] known_length
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] WORD_MASK = (DEF_WIDTH >= 64) ? '1 :
		((64'd1 << DEF_WIDTH) - 64'd1);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  read_value;
		logic [IDX_W-1:0]  found_index;
		logic [LEN_W-1:0]  list_length;
	} outcome_t;

	logic [VAL_W-1:0] list_mem [DEF_DEPTH];
	int               list_len;
	outcome_t         expected_q[$];
	outcome_t         want;

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] exp_val);
		$display("%0t ns: %s got %0h, predicted %0h", $time, what, got, exp_val);
		fail_count++;
	endtask

	// Applies one request to the shadow list and returns the result it should give.
	function automatic outcome_t apply_request(input logic [OP_W-1:0] op,
		input logic [POS_W-1:0] pos_in, input logic [VAL_W-1:0] val_in);
		outcome_t         res;
		int               pos;
		int               k;
		int               lo;
		int               hi;
		logic [VAL_W-1:0] val;
		logic [VAL_W-1:0] tmp;
		res = '0;
		res.status = ST_OK;
		pos = int'(pos_in);
		val = val_in & WORD_MASK[VAL_W-1:0];
		case (op)
			OP_INSERT: begin
				if (pos > list_len) begin
					res.status = ST_BAD_POS;
				end else if (list_len >= DEF_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (k = list_len; k > pos; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (pos >= list_len) begin
					res.status = ST_BAD_POS;
				end else begin
					for (k = pos; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
				end
			end
			OP_SEARCH: begin
				res.status = ST_NOT_FOUND;
				for (k = 0; k < list_len; k++) begin
					if (list_mem[k] == val) begin
						res.status = ST_OK;
						res.found_index = k[IDX_W-1:0];
						break;
					end
				end
			end
			OP_READ: begin
				if (pos >= list_len)
					res.status = ST_BAD_POS;
				else
					res.read_value = list_mem[pos];
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			OP_REVERSE: begin
				lo = 0;
				hi = list_len - 1;
				while (lo < hi) begin
					tmp = list_mem[lo];
					list_mem[lo] = list_mem[hi];
					list_mem[hi] = tmp;
					lo++;
					hi--;
				end
			end
			default: begin
			end
		endcase
		res.list_length = list_len[LEN_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_q.delete();
			pending_count <= 0;
			known_length <= '0;
		end else begin
			// A result leaving at this edge belongs to an earlier item, so pop first.
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing outstanding, status", 64'(rsp.status),
						64'(0));
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", 64'(rsp.read_value),
							64'(want.read_value));
					if (rsp.found_index !== want.found_index)
						report_mismatch("found_index", 64'(rsp.found_index),
							64'(want.found_index));
					if (rsp.list_length !== want.list_length)
						report_mismatch("list_length", 64'(rsp.list_length),
							64'(want.list_length));
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(apply_request(req.operation, req.position,
					req.item_value));
			pending_count <= expected_q.size();
			known_length <= list_len[LEN_W-1:0];
		end
	end

endmodule

// ----- test/tb.sv -----
// Top of the positional list engine test: clock, reset, request stimulus and
// result back-pressure; the verdict comes from the failure count of ple_checker.
// Depends on ple_pkg, ple_if, positional_list_engine and ple_checker.
module tb import ple_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1450;
	localparam int LONG_HOLD    = 300;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

	logic             clk;
	logic             arst_n;
	int               fail_count;
	int               pending_count;
	logic [LEN_W-1:0] known_length;
	logic [VAL_W-1:0] value_pool [12];
	bit               send_quiet;
	bit               take_quiet;

	ple_req_if req_ch();
	ple_rsp_if rsp_ch();

	positional_list_engine #(.DEPTH(DEF_DEPTH), .WIDTH(DEF_WIDTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ple_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.known_length  (known_length)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#80_000_000;
		$display("positional_list_engine test failed");
		$finish;
	end

	// Offers one item after a random gap and returns once it has been accepted.
	task automatic offer_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
		input logic [VAL_W-1:0] val);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.position   <= pos;
		req_ch.item_value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] draw_value();
		if ($urandom_range(0, 9) < 7)
			return value_pool[$urandom_range(0, 11)];
		return $urandom();
	endfunction

	// Position inside the list most of the time; allow_end admits the append slot.
	function automatic logic [POS_W-1:0] draw_position(input bit allow_end);
		int top;
		if ($urandom_range(0, 99) < 8)
			return POS_W'($urandom_range(0, 255));
		top = int'(known_length) - (allow_end ? 0 : 1);
		if (top > 255)
			top = 255;
		if (top < 0)
			top = 0;
		return POS_W'($urandom_range(0, top));
	endfunction

	task automatic random_request(input traffic_mode_t mode, output bit useful);
		int               r;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_GROW:
				op = (r < 85) ? OP_INSERT : (r < 90) ? OP_SEARCH : (r < 94) ? OP_READ :
					(r < 97) ? OP_REMOVE : (r < 99) ? OP_REVERSE : OP_SPARE_LO;
			MODE_SHRINK:
				op = (r < 70) ? OP_REMOVE : (r < 80) ? OP_SEARCH : (r < 90) ? OP_READ :
					(r < 95) ? OP_INSERT : (r < 99) ? OP_REVERSE : OP_SPARE_HI;
			default:
				op = (r < 35) ? OP_INSERT : (r < 60) ? OP_REMOVE : (r < 75) ? OP_SEARCH :
					(r < 87) ? OP_READ : (r < 93) ? OP_REVERSE : (r < 95) ? OP_CLEAR :
					(r < 97) ? OP_SPARE_LO : OP_SPARE_HI;
		endcase
		case (op)
			OP_INSERT:           pos = draw_position(1'b1);
			OP_REMOVE, OP_READ:  pos = draw_position(1'b0);
			default:             pos = POS_W'($urandom_range(0, 255));
		endcase
		val = (op == OP_INSERT || op == OP_SEARCH) ? draw_value() : $urandom();
		useful = (op != OP_SPARE_LO && op != OP_SPARE_HI);
		offer_request(op, pos, val);
	endtask

	// Result side: random stalls per item, two long hold-offs to fill the block.
	initial begin
		int gap;
		int taken;
		rsp_ch.ready <= 1'b0;
		taken = 0;
		take_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_quiet = !take_quiet;
			gap = take_quiet ? 0 : $urandom_range(0, 11);
			if (taken == 400 || taken == 1000)
				gap = LONG_HOLD;
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		int            sent;
		int            burst;
		bit            useful;
		traffic_mode_t mode;
		req_ch.valid      <= 1'b0;
		req_ch.operation  <= OP_INSERT;
		req_ch.position   <= '0;
		req_ch.item_value <= '0;
		send_quiet = 1'b0;
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int i = 2; i < 12; i++)
			value_pool[i] = $urandom();
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Empty list corner cases first.
		offer_request(OP_READ,    8'd0,   32'h0);
		offer_request(OP_REMOVE,  8'd0,   32'h0);
		offer_request(OP_SEARCH,  8'd0,   32'h0);
		offer_request(OP_REVERSE, 8'd0,   32'h0);
		offer_request(OP_CLEAR,   8'd0,   32'h0);
		offer_request(OP_INSERT,  8'd1,   32'h1);
		// Build a short list, shifting entries up at the front.
		offer_request(OP_INSERT,  8'd0,   32'hFFFF_FFFF);
		offer_request(OP_INSERT,  8'd1,   32'h0000_0000);
		offer_request(OP_INSERT,  8'd0,   32'hA5A5_A5A5);
		offer_request(OP_INSERT,  8'd4,   32'h1234_5678);
		offer_request(OP_INSERT,  8'd3,   32'h5A5A_5A5A);
		offer_request(OP_READ,    8'd3,   32'h0);
		offer_request(OP_READ,    8'd4,   32'h0);
		offer_request(OP_SEARCH,  8'd0,   32'h0000_0000);
		offer_request(OP_SEARCH,  8'd0,   32'h1234_5678);
		offer_request(OP_REVERSE, 8'd0,   32'h0);
		offer_request(OP_READ,    8'd0,   32'h0);
		offer_request(OP_REMOVE,  8'd0,   32'h0);
		offer_request(OP_REMOVE,  8'd255, 32'h0);
		offer_request(OP_SPARE_LO, 8'd255, 32'hFFFF_FFFF);
		offer_request(OP_SPARE_HI, 8'd0,  32'h0);
		offer_request(OP_READ,    8'd255, 32'h0);
		offer_request(OP_CLEAR,   8'd0,   32'h0);
		offer_request(OP_INSERT,  8'd0,   32'hC3C3_C3C3);
		offer_request(OP_REVERSE, 8'd0,   32'h0);

		// The first burst grows the list until it is full and inserts bounce off it.
		sent = 0;
		mode = MODE_GROW;
		burst = 340;
		while (sent < RANDOM_ITEMS) begin
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				random_request(mode, useful);
				if (useful)
					sent++;
			end
			mode = traffic_mode_t'($urandom_range(0, 2));
			burst = $urandom_range(80, 250);
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("positional_list_engine test passed");
		else
			$display("positional_list_engine test failed");
		$finish;
	end

endmodule
